FILE: hdl/pct_pkg.sv
`timescale 1ns / 1ps

package pct_pkg;

  // Default coordinate width, signed Q8.8 at sixteen bits.
  localparam int unsigned COORD_BITS_DEF = 16;

  // Width of the collinearity threshold register.
  localparam int unsigned TOL_BITS = 16;

  // Direction of the turn at one vertex.
  typedef enum logic [1:0] {
    TURN_NONE = 2'd0,
    TURN_POS  = 2'd1,
    TURN_NEG  = 2'd2
  } turn_e;

endpackage

FILE: hdl/polygon_convexity_test_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// vertex    in         in_valid_i / in_stall_o    coord_x_i, coord_y_i, last_vertex_i
// result    out        out_valid_o / out_stall_i  convex_flag_o, too_few_vertices_o
// config    in         cfg_we_i                   cfg_wdata_i (turn tolerance)
//
// Sustained rate is one vertex per cycle while the input does not stall. A vertex is held
// in an input register; when it moves on, three cross product units (the regular turn and
// both closing turns) update the polygon state and load the result register. Reset clears
// the control state and the tolerance register. The input side stalls only when a last
// vertex waits behind a result that is itself stalled.

module polygon_convexity_test_top #(
  parameter int unsigned COORD_BITS = pct_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pct_pkg::TOL_BITS-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  input  logic                         last_vertex_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         convex_flag_o,
  output logic                         too_few_vertices_o
);
  import pct_pkg::*;

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned CP = 2 * W + 3;

  typedef logic signed [W-1:0] coord_t;

  // Sign of (b - a) x (c - b), or none when the magnitude is within the tolerance.
  function automatic turn_e turn_of(input coord_t ax, input coord_t ay,
                                    input coord_t bx, input coord_t by,
                                    input coord_t cx, input coord_t cy,
                                    input logic [TOL_BITS-1:0] tol);
    logic signed [W:0]      e1x, e1y, e2x, e2y;
    logic signed [2*W+1:0]  p, q;
    logic signed [CP-1:0]   d, tol_s, ntol_s;
    turn_e                  r;
    e1x    = $signed({bx[W-1], bx}) - $signed({ax[W-1], ax});
    e1y    = $signed({by[W-1], by}) - $signed({ay[W-1], ay});
    e2x    = $signed({cx[W-1], cx}) - $signed({bx[W-1], bx});
    e2y    = $signed({cy[W-1], cy}) - $signed({by[W-1], by});
    p      = e1x * e2y;
    q      = e1y * e2x;
    d      = $signed({p[2*W+1], p}) - $signed({q[2*W+1], q});
    tol_s  = $signed({{(CP - TOL_BITS){1'b0}}, tol});
    ntol_s = -tol_s;
    if (d > tol_s) begin
      r = TURN_POS;
    end else if (d < ntol_s) begin
      r = TURN_NEG;
    end else begin
      r = TURN_NONE;
    end
    return r;
  endfunction

  logic [TOL_BITS-1:0] tol_q;

  // Input register.
  logic   in_vld_q, in_last_q;
  coord_t in_x_q, in_y_q;

  // Polygon state.
  coord_t      first_x_q, first_y_q, second_x_q, second_y_q;
  coord_t      older_x_q, older_y_q, newer_x_q, newer_y_q;
  logic [1:0]  seen_q, seen_d;
  turn_e       sign_q, sign_d;
  logic        mism_q, mism_d;

  // Result register.
  logic out_vld_q, out_convex_q, out_few_q;
  logic out_vld_d, out_convex_d, out_few_d;

  logic  advance, enough;
  turn_e t_mid, t_close_a, t_close_b;

  // A vertex moves on unless it closes a polygon while the result register is held.
  assign advance    = in_vld_q && (!in_last_q || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_x_q    <= coord_x_i;
      in_y_q    <= coord_y_i;
      in_last_q <= last_vertex_i;
    end
  end

  assign t_mid     = turn_of(older_x_q, older_y_q, newer_x_q, newer_y_q, in_x_q, in_y_q, tol_q);
  assign t_close_a = turn_of(newer_x_q, newer_y_q, in_x_q, in_y_q, first_x_q, first_y_q, tol_q);
  assign t_close_b = turn_of(in_x_q, in_y_q, first_x_q, first_y_q, second_x_q, second_y_q,
                             tol_q);
  assign enough    = (seen_q >= 2'd2);

  always_comb begin
    turn_e s;
    logic  m;
    s = sign_q;
    m = mism_q;
    // The regular turn comes first, then the two closing turns in polygon order.
    if (enough && t_mid != TURN_NONE) begin
      if (s == TURN_NONE) s = t_mid;
      else if (s != t_mid) m = 1'b1;
    end
    if (enough && in_last_q && t_close_a != TURN_NONE) begin
      if (s == TURN_NONE) s = t_close_a;
      else if (s != t_close_a) m = 1'b1;
    end
    if (enough && in_last_q && t_close_b != TURN_NONE) begin
      if (s == TURN_NONE) s = t_close_b;
      else if (s != t_close_b) m = 1'b1;
    end

    seen_d       = seen_q;
    sign_d       = sign_q;
    mism_d       = mism_q;
    out_convex_d = out_convex_q;
    out_few_d    = out_few_q;
    out_vld_d    = out_vld_q && out_stall_i;
    if (advance) begin
      if (in_last_q) begin
        seen_d       = 2'd0;
        sign_d       = TURN_NONE;
        mism_d       = 1'b0;
        out_vld_d    = 1'b1;
        out_convex_d = enough && !m;
        out_few_d    = !enough;
      end else begin
        seen_d = (seen_q == 2'd3) ? seen_q : seen_q + 2'd1;
        sign_d = s;
        mism_d = m;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= 2'd0;
      sign_q    <= TURN_NONE;
      mism_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      seen_q    <= seen_d;
      sign_q    <= sign_d;
      mism_q    <= mism_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_convex_q <= out_convex_d;
    out_few_q    <= out_few_d;
  end

  // Vertex registers are only read once the vertex count says they hold data.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (seen_q == 2'd0) begin
        first_x_q <= in_x_q;
        first_y_q <= in_y_q;
      end
      if (seen_q == 2'd1) begin
        second_x_q <= in_x_q;
        second_y_q <= in_y_q;
      end
      older_x_q <= newer_x_q;
      older_y_q <= newer_y_q;
      newer_x_q <= in_x_q;
      newer_y_q <= in_y_q;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign convex_flag_o      = out_convex_q;
  assign too_few_vertices_o = out_few_q;

endmodule

FILE: hdl/pct_checker.sv
`timescale 1ns / 1ps

module pct_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic convex_flag_o,
  input logic too_few_vertices_o
);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A held result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(convex_flag_o) && $stable(too_few_vertices_o))
    else $error("result payload changed while stalled");

  // A polygon that is too small is never reported convex.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(convex_flag_o && too_few_vertices_o))
    else $error("convex and too few vertices both set");

  // With no result waiting, the vertex input never stalls.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

endmodule

bind polygon_convexity_test_top pct_checker u_pct_checker (.*);
